// ===== rtl/core/msep_pkg.sv =====
package msep_pkg;

    localparam int BYTE_W   = 8;
    localparam int EVENT_W  = 3;
    localparam int SYSEX_W  = 9;
    localparam int SKIP_W   = 2;
    localparam int TDATA_OUT_W = 8;

    localparam logic [SYSEX_W-1:0] SYSEX_MAX_RESET = 9'd256;
    localparam logic [BYTE_W-1:0]  EOX_BYTE        = 8'hF7;

    // upper nibble of a status byte
    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_CTRL_CHG   = 4'hB;
    localparam logic [3:0] ST_PROG_CHG   = 4'hC;
    localparam logic [3:0] ST_PITCH_BEND = 4'hE;
    localparam logic [3:0] ST_SYSTEM     = 4'hF;

    // lower nibble of a system byte
    localparam logic [3:0] SYS_SYSEX    = 4'h0;
    localparam logic [3:0] SYS_SONG_POS = 4'h2;
    localparam logic [3:0] SYS_CLOCK    = 4'h8;
    localparam logic [3:0] SYS_START    = 4'hA;
    localparam logic [3:0] SYS_CONTINUE = 4'hB;
    localparam logic [3:0] SYS_STOP     = 4'hC;

    // sync event codes
    localparam logic [EVENT_W-1:0] EV_TRIGGER  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CLOCK    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_START    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_CONTINUE = 3'd3;
    localparam logic [EVENT_W-1:0] EV_STOP     = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SKIP  = 4'b0010,
        PH_NOTE  = 4'b0100,
        PH_SYSEX = 4'b1000
    } msep_phase_t;

    typedef struct packed {
        logic                hit;
        logic [EVENT_W-1:0]  sync_event;
    } msep_result_t;

endpackage

// ===== rtl/core/msep_in_reg.sv =====
module msep_in_reg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       drain,
    input  logic [msep_pkg::BYTE_W-1:0] byte_in,
    output logic                       valid,
    output logic [msep_pkg::BYTE_W-1:0] byte_out
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [msep_pkg::BYTE_W-1:0] byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: hold unless a new transfer lands
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_in;
        end
    end

    assign valid    = valid_reg;
    assign byte_out = byte_reg;

endmodule

// ===== rtl/core/msep_decoder.sv =====
module msep_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [msep_pkg::SYSEX_W-1:0]  cfg_wdata,
    input  logic                          step,
    input  logic [msep_pkg::BYTE_W-1:0]   rx_byte,
    output msep_pkg::msep_result_t        result
);

    msep_pkg::msep_phase_t               phase_reg;
    msep_pkg::msep_phase_t               phase_next;
    logic [msep_pkg::SKIP_W-1:0]         skip_reg;
    logic [msep_pkg::SKIP_W-1:0]         skip_next;
    logic [msep_pkg::SYSEX_W-1:0]        count_reg;
    logic [msep_pkg::SYSEX_W-1:0]        count_next;
    logic [msep_pkg::SYSEX_W-1:0]        sysex_max_reg;
    logic [msep_pkg::SKIP_W-1:0]         skip_dec;
    logic [msep_pkg::SYSEX_W-1:0]        count_inc;
    logic [3:0]                          hi_nib;
    logic [3:0]                          lo_nib;

    assign hi_nib    = rx_byte[7:4];
    assign lo_nib    = rx_byte[3:0];
    assign skip_dec  = (skip_reg != '0) ? skip_reg - 2'd1 : skip_reg;
    assign count_inc = count_reg + 9'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        skip_next         = skip_reg;
        count_next        = count_reg;
        result.hit        = 1'b0;
        result.sync_event = msep_pkg::EV_TRIGGER;
        if (step)
        begin
            unique case (phase_reg)
                msep_pkg::PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = msep_pkg::PH_IDLE;
                    end
                end
                msep_pkg::PH_NOTE:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = msep_pkg::PH_IDLE;
                        // zero velocity is a note off in disguise: drop it
                        result.hit = (rx_byte != '0);
                    end
                end
                msep_pkg::PH_SYSEX:
                begin
                    if (rx_byte == msep_pkg::EOX_BYTE)
                    begin
                        phase_next = msep_pkg::PH_IDLE;
                        count_next = '0;
                    end
                    else if (count_inc >= sysex_max_reg)
                    begin
                        phase_next = msep_pkg::PH_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    phase_next = msep_pkg::PH_IDLE;
                    unique case (hi_nib)
                        msep_pkg::ST_NOTE_ON:
                        begin
                            phase_next = msep_pkg::PH_NOTE;
                            skip_next  = 2'd2;
                        end
                        msep_pkg::ST_NOTE_OFF,
                        msep_pkg::ST_CTRL_CHG,
                        msep_pkg::ST_PITCH_BEND:
                        begin
                            phase_next = msep_pkg::PH_SKIP;
                            skip_next  = 2'd2;
                        end
                        msep_pkg::ST_PROG_CHG:
                        begin
                            phase_next = msep_pkg::PH_SKIP;
                            skip_next  = 2'd1;
                        end
                        msep_pkg::ST_SYSTEM:
                        begin
                            unique case (lo_nib)
                                msep_pkg::SYS_CLOCK:
                                begin
                                    result.hit        = 1'b1;
                                    result.sync_event = msep_pkg::EV_CLOCK;
                                end
                                msep_pkg::SYS_START:
                                begin
                                    result.hit        = 1'b1;
                                    result.sync_event = msep_pkg::EV_START;
                                end
                                msep_pkg::SYS_CONTINUE:
                                begin
                                    result.hit        = 1'b1;
                                    result.sync_event = msep_pkg::EV_CONTINUE;
                                end
                                msep_pkg::SYS_STOP:
                                begin
                                    result.hit        = 1'b1;
                                    result.sync_event = msep_pkg::EV_STOP;
                                end
                                msep_pkg::SYS_SONG_POS:
                                begin
                                    phase_next = msep_pkg::PH_SKIP;
                                    skip_next  = 2'd2;
                                end
                                msep_pkg::SYS_SYSEX:
                                begin
                                    count_next = '0;
                                    if (sysex_max_reg != '0)
                                    begin
                                        phase_next = msep_pkg::PH_SYSEX;
                                    end
                                end
                                default:
                                begin
                                    phase_next = msep_pkg::PH_IDLE;
                                end
                            endcase
                        end
                        default:
                        begin
                            phase_next = msep_pkg::PH_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= msep_pkg::PH_IDLE;
            skip_reg      <= '0;
            count_reg     <= '0;
            sysex_max_reg <= msep_pkg::SYSEX_MAX_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                sysex_max_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/core/msep_out_reg.sv =====
module msep_out_reg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  msep_pkg::msep_result_t            result,
    input  logic                              take,
    output logic                              can_load,
    output logic                              valid,
    output logic [msep_pkg::EVENT_W-1:0]      sync_event
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [msep_pkg::EVENT_W-1:0]   event_reg;
    logic                           load;

    assign load     = step && result.hit;
    assign can_load = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= result.sync_event;
        end
    end

    assign valid      = valid_reg;
    assign sync_event = event_reg;

endmodule

// ===== rtl/core/midi_sync_event_parser_core.sv =====
// Path: input register, decode, result register; a byte's result is loaded when the byte steps.
// Throughput: one byte per cycle while the result register is not held by a stalled receiver.
// Bytes that cause no result (data, ignored status) step the same way and produce nothing.
// A result held by a stalled receiver holds the input: no byte advances until it is taken.
// Reset (rst_n low, asynchronous) empties both registers, puts the parser in status
// position with no bytes to skip, and sets sysex_max to 256.
module midi_sync_event_parser_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [msep_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] rx_byte
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [msep_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,  // [2:0] sync_event, [7:3] zero
    // configuration
    input  logic                               sysex_max_wr_en,
    input  logic [msep_pkg::SYSEX_W-1:0]       sysex_max_wr_data
);

    logic                                in_valid;
    logic [msep_pkg::BYTE_W-1:0]         in_byte;
    logic                                out_can_load;
    logic                                step;
    logic                                in_xfer;
    logic                                out_xfer;
    logic [msep_pkg::EVENT_W-1:0]        out_event;
    msep_pkg::msep_result_t              result;

    // Advance the held byte whenever the result register can take its outcome;
    // a byte without a result advances the same way.
    assign step          = in_valid && out_can_load;
    assign s_axis_tready = !in_valid || step;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    msep_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_xfer),
        .drain    (step),
        .byte_in  (s_axis_tdata),
        .valid    (in_valid),
        .byte_out (in_byte)
    );

    // Framing state and the sysex limit live here; state moves only on a step.
    msep_decoder u_decoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (sysex_max_wr_en),
        .cfg_wdata (sysex_max_wr_data),
        .step      (step),
        .rx_byte   (in_byte),
        .result    (result)
    );

    msep_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .result     (result),
        .take       (out_xfer),
        .can_load   (out_can_load),
        .valid      (m_axis_tvalid),
        .sync_event (out_event)
    );

    // Pad the event code to a whole byte.
    assign m_axis_tdata = {{(msep_pkg::TDATA_OUT_W - msep_pkg::EVENT_W){1'b0}}, out_event};

endmodule

// ===== rtl/core/msep_checker.sv =====
module msep_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // hold a pending result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // only the five defined event codes ever leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0) &&
                          (m_axis_tdata[2:0] <= msep_pkg::EV_STOP))
        else $error("undefined event code");

    // with the result register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

bind midi_sync_event_parser_core msep_checker u_msep_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
